@@ rtl/sbr_pkg.sv @@
package sbr_pkg;

  // default bundle width and fixed field widths
  localparam int unsigned MAX_STREAMS_DEF = 64;
  localparam int unsigned LEVEL_W         = 7;
  localparam int unsigned CFG_IDX_W       = 8;
  localparam int unsigned CFG_DATA_W      = 8;

  localparam logic [LEVEL_W-1:0] STREAM_COUNT_RESET = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE         = 8'd0,
    CFG_STREAM_COUNT = 8'd1
  } cfg_reg_e;

  typedef enum logic {
    MODE_ADD  = 1'b0,
    MODE_TANH = 1'b1
  } mode_e;

endpackage

@@ rtl/sbr_if.sv @@
interface sbr_bundle_if #(
  parameter int unsigned W = 64
);
  logic         valid;
  logic         ready;
  logic [W-1:0] bundle_bits;
  logic         last;

  modport source (output valid, bundle_bits, last, input ready);
  modport sink   (input valid, bundle_bits, last, output ready);
endinterface

interface sbr_result_if;
  logic       valid;
  logic       ready;
  logic       out_bit;
  logic [6:0] level;

  modport source (output valid, out_bit, level, input ready);
  modport sink   (input valid, out_bit, level, output ready);
endinterface

interface sbr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/stochastic_bundle_reducer.sv @@
// Stochastic bundle reducer: each bundle transfer carries the current bit of up to
// MAX_STREAMS stochastic streams and yields one result transfer with the output stream
// bit and the counter level after the update. Mode 0 adds the count of ones and emits
// a one each time the counter reaches N (scaled addition); mode 1 moves the counter by
// ones minus zeros, saturated to 0..2N-1, and emits a one above N-1 (stochastic tanh).
// Only the low N = stream_count bits count; zero is taken as 1 and values above
// MAX_STREAMS as MAX_STREAMS. The counter clears after a transfer marked last.
// Throughput is one transfer per clock while the result side accepts results; the
// masked popcount is registered first, then the counter update fills the result
// register. The popcount tree and the single counter update set the clock.
// Write registers only while no transfer is in flight.
module stochastic_bundle_reducer
  import sbr_pkg::*;
#(
  parameter int unsigned MAX_STREAMS = MAX_STREAMS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sbr_cfg_if.sink              cfg_i,
  sbr_bundle_if.sink           bundle_i,
  sbr_result_if.source         result_o
);

  localparam int unsigned ONES_W = $clog2(MAX_STREAMS + 1);
  localparam int unsigned GROUPS = (MAX_STREAMS + 7) / 8;

  // configuration registers
  mode_e              mode_q;
  logic [LEVEL_W-1:0] stream_count_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= MODE_ADD;
      stream_count_q <= STREAM_COUNT_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_MODE:         mode_q         <= mode_e'(cfg_i.data[0]);
        CFG_STREAM_COUNT: stream_count_q <= cfg_i.data[LEVEL_W-1:0];
        default:          ;
      endcase
    end
  end

  // effective stream count, clamped to 1..MAX_STREAMS
  logic [LEVEL_W-1:0] n_eff;
  always_comb begin
    if (stream_count_q == '0) begin
      n_eff = LEVEL_W'(1);
    end else if (stream_count_q > LEVEL_W'(MAX_STREAMS)) begin
      n_eff = LEVEL_W'(MAX_STREAMS);
    end else begin
      n_eff = stream_count_q;
    end
  end

  // pipeline handshake: stage 1 holds popcount, stage 2 is the result register
  logic s1_valid_q, out_valid_q;
  logic out_free, s1_adv, in_xfer;

  assign out_free       = !out_valid_q || result_o.ready;
  assign s1_adv         = s1_valid_q && out_free;
  assign bundle_i.ready = !s1_valid_q || out_free;
  assign in_xfer        = bundle_i.valid && bundle_i.ready;

  // masked popcount, summed per byte then across bytes
  logic [GROUPS*8-1:0] masked;
  logic [ONES_W-1:0]   ones_d;
  always_comb begin
    logic [3:0] grp;
    masked = '0;
    for (int i = 0; i < MAX_STREAMS; i++) begin
      masked[i] = bundle_i.bundle_bits[i] && (i < int'(n_eff));
    end
    ones_d = '0;
    for (int g = 0; g < GROUPS; g++) begin
      grp = '0;
      for (int b = 0; b < 8; b++) begin
        grp = grp + 4'(masked[g*8+b]);
      end
      ones_d = ones_d + ONES_W'(grp);
    end
  end

  logic [ONES_W-1:0] ones_q;
  logic              last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (bundle_i.ready) begin
      s1_valid_q <= bundle_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ones_q <= ones_d;
      last_q <= bundle_i.last;
    end
  end

  // counter update
  logic [LEVEL_W-1:0] acc_q, level_d;
  logic               bit_d;
  logic [LEVEL_W:0]   add_sum, add_sub;
  logic signed [9:0]  tanh_sum, tanh_top;

  always_comb begin
    add_sum  = {1'b0, acc_q} + (LEVEL_W+1)'(ones_q);
    add_sub  = add_sum - {1'b0, n_eff};
    tanh_sum = $signed({3'b000, acc_q}) + $signed(10'(ones_q) << 1)
             - $signed({3'b000, n_eff});
    tanh_top = $signed({2'b00, n_eff, 1'b0}) - 10'sd1;
    case (mode_q)
      MODE_ADD: begin
        bit_d = (add_sum >= {1'b0, n_eff});
        if (bit_d) begin
          level_d = add_sub[LEVEL_W] ? '1 : add_sub[LEVEL_W-1:0];
        end else begin
          level_d = add_sum[LEVEL_W] ? '1 : add_sum[LEVEL_W-1:0];
        end
      end
      MODE_TANH: begin
        if (tanh_sum > tanh_top) begin
          level_d = tanh_top[LEVEL_W-1:0];
        end else if (tanh_sum < 10'sd0) begin
          level_d = '0;
        end else begin
          level_d = tanh_sum[LEVEL_W-1:0];
        end
        bit_d = (level_d >= n_eff);
      end
      default: begin
        bit_d   = 1'b0;
        level_d = acc_q;
      end
    endcase
  end

  logic               out_bit_q;
  logic [LEVEL_W-1:0] level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      acc_q       <= '0;
    end else begin
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_adv) begin
        // clear after the end of the streams
        acc_q <= last_q ? '0 : level_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_bit_q <= bit_d;
      level_q   <= level_d;
    end
  end

  assign result_o.valid   = out_valid_q;
  assign result_o.out_bit = out_bit_q;
  assign result_o.level   = level_q;

  // counter is cleared once a last transfer has been reduced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && last_q) |=> (acc_q == '0))
    else $error("counter not cleared after last transfer");

  // tanh mode keeps the counter within 0..2N-1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && mode_q == MODE_TANH) |-> ({1'b0, level_d} < {n_eff, 1'b0}))
    else $error("tanh counter out of range");

  // a stalled stage 1 item never blocks the bundle side unless the result side is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!bundle_i.ready) |-> (s1_valid_q && out_valid_q && !result_o.ready))
    else $error("bundle side stalled without back pressure");

  // a held result keeps its level while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_o.ready) |=> (out_valid_q && $stable(level_q)))
    else $error("result changed under stall");

endmodule
